### rtl/core/nec_ir_frame_decoder_assert.svh
// Assertion macros shared by the NEC IR frame decoder RTL.
// Expects clk and arst_n in the including module's scope.
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define NIR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nir assertion failed");

// next-cycle implication
`define NIR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nir assertion failed");

`endif

### rtl/core/nir_pkg.sv
// Shared types and constants for the NEC IR frame decoder.
// No dependencies.
package nir_pkg;

	localparam int FRAME_BITS_DEF = 32;
	localparam int WORD_W         = 32;
	localparam int TIME_W         = 16;
	localparam int ADDR_W         = 8;
	localparam int CFG_IDX_W      = 3;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	localparam logic [TIME_W-1:0] LEADER_MIN_RST = 16'd13000;
	localparam logic [TIME_W-1:0] LEADER_MAX_RST = 16'd14000;
	localparam logic [TIME_W-1:0] ZERO_MIN_RST   = 16'd1000;
	localparam logic [TIME_W-1:0] ZERO_MAX_RST   = 16'd1300;
	localparam logic [TIME_W-1:0] ONE_MIN_RST    = 16'd2100;
	localparam logic [TIME_W-1:0] ONE_MAX_RST    = 16'd2400;
	localparam logic [ADDR_W-1:0] ADDR_RST       = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEADER_MIN = 3'd0,
		REG_LEADER_MAX = 3'd1,
		REG_ZERO_MIN   = 3'd2,
		REG_ZERO_MAX   = 3'd3,
		REG_ONE_MIN    = 3'd4,
		REG_ONE_MAX    = 3'd5,
		REG_ADDRESS    = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_BUSY   = 2'd0,
		ST_TIMING = 2'd1,
		ST_OK     = 2'd2,
		ST_BAD    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_LEADER = 3'b010,
		PH_BITS   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [TIME_W-1:0] leader_min;
		logic [TIME_W-1:0] leader_max;
		logic [TIME_W-1:0] zero_min;
		logic [TIME_W-1:0] zero_max;
		logic [TIME_W-1:0] one_min;
		logic [TIME_W-1:0] one_max;
		logic [ADDR_W-1:0] address;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [7:0]        command;
		logic [WORD_W-1:0] frame_word;
	} result_t;

endpackage

### rtl/core/nir_cfg.sv
// Configuration register file of the NEC IR frame decoder.
// Depends on nir_pkg.
module nir_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nir_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nir_pkg::TIME_W-1:0]          cfg_data,
	output nir_pkg::cfg_t                       cfg
);

	nir_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_min <= nir_pkg::LEADER_MIN_RST;
			cfg_q.leader_max <= nir_pkg::LEADER_MAX_RST;
			cfg_q.zero_min   <= nir_pkg::ZERO_MIN_RST;
			cfg_q.zero_max   <= nir_pkg::ZERO_MAX_RST;
			cfg_q.one_min    <= nir_pkg::ONE_MIN_RST;
			cfg_q.one_max    <= nir_pkg::ONE_MAX_RST;
			cfg_q.address    <= nir_pkg::ADDR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (nir_pkg::reg_idx_t'(cfg_index))
				nir_pkg::REG_LEADER_MIN: cfg_q.leader_min <= cfg_data;
				nir_pkg::REG_LEADER_MAX: cfg_q.leader_max <= cfg_data;
				nir_pkg::REG_ZERO_MIN:   cfg_q.zero_min   <= cfg_data;
				nir_pkg::REG_ZERO_MAX:   cfg_q.zero_max   <= cfg_data;
				nir_pkg::REG_ONE_MIN:    cfg_q.one_min    <= cfg_data;
				nir_pkg::REG_ONE_MAX:    cfg_q.one_max    <= cfg_data;
				nir_pkg::REG_ADDRESS:    cfg_q.address    <= cfg_data[nir_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/nir_core.sv
// Per-edge frame state machine: window compares, bit shift and frame check.
// Depends on nir_pkg and nec_ir_frame_decoder_assert.svh.
`include "nec_ir_frame_decoder_assert.svh"

module nir_core #(
	parameter int FRAME_BITS = nir_pkg::FRAME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [nir_pkg::TIME_W-1:0]   interval_us,
	input  nir_pkg::cfg_t                cfg,
	output nir_pkg::result_t             result
);

	localparam int BL_W = $clog2(FRAME_BITS + 1);

	nir_pkg::phase_t               phase_q, phase_d;
	logic [BL_W-1:0]               bits_left_q, bits_left_d;
	logic [nir_pkg::WORD_W-1:0]    shift_q, shift_d;
	nir_pkg::status_t              status_d;
	logic [7:0]                    cmd_d;
	logic                          lead_hit, zero_hit, one_hit, frame_good;

	assign lead_hit = (cfg.leader_min < interval_us) && (interval_us < cfg.leader_max);
	assign zero_hit = (cfg.zero_min < interval_us) && (interval_us < cfg.zero_max);
	assign one_hit  = (cfg.one_min < interval_us) && (interval_us < cfg.one_max);

	assign frame_good = ((shift_d[31:24] ^ shift_d[23:16]) == nir_pkg::BYTE_ONES)
		&& ((shift_d[15:8] ^ shift_d[7:0]) == nir_pkg::BYTE_ONES)
		&& (shift_d[31:24] == cfg.address);

	always_comb begin
		phase_d     = phase_q;
		bits_left_d = bits_left_q;
		shift_d     = shift_q;
		status_d    = nir_pkg::ST_BUSY;
		cmd_d       = '0;
		case (phase_q)
			nir_pkg::PH_IDLE: begin
				phase_d = nir_pkg::PH_LEADER;
			end
			nir_pkg::PH_LEADER: begin
				if (lead_hit) begin
					phase_d     = nir_pkg::PH_BITS;
					bits_left_d = BL_W'(FRAME_BITS);
					shift_d     = '0;
				end else begin
					phase_d  = nir_pkg::PH_IDLE;
					status_d = nir_pkg::ST_TIMING;
				end
			end
			nir_pkg::PH_BITS: begin
				if (zero_hit || one_hit) begin
					// zero window wins on overlap
					shift_d     = {shift_q[nir_pkg::WORD_W-2:0], ~zero_hit};
					bits_left_d = bits_left_q - 1'b1;
					if (bits_left_d == '0) begin
						phase_d = nir_pkg::PH_IDLE;
						if (frame_good) begin
							status_d = nir_pkg::ST_OK;
							cmd_d    = shift_d[15:8];
						end else begin
							status_d = nir_pkg::ST_BAD;
						end
					end
				end else begin
					phase_d  = nir_pkg::PH_IDLE;
					status_d = nir_pkg::ST_TIMING;
				end
			end
			default: begin
				phase_d  = nir_pkg::PH_IDLE;
				status_d = nir_pkg::ST_TIMING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= nir_pkg::PH_IDLE;
			bits_left_q <= '0;
			shift_q     <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			bits_left_q <= bits_left_d;
			shift_q     <= shift_d;
		end
	end

	assign result.status     = status_d;
	assign result.command    = cmd_d;
	assign result.frame_word = shift_d;

	`NIR_ASSERT_NEXT(a_end_goes_idle, step && (status_d != nir_pkg::ST_BUSY),
		phase_q == nir_pkg::PH_IDLE)
	`NIR_ASSERT_NEXT(a_busy_bits_left, step && (phase_q == nir_pkg::PH_BITS)
		&& (status_d == nir_pkg::ST_BUSY), bits_left_q != '0)
	`NIR_ASSERT_NOW(a_cmd_only_ok, (status_d != nir_pkg::ST_OK), cmd_d == '0)

endmodule

### rtl/core/nec_ir_frame_decoder.sv
// NEC IR frame decoder: one beat in per receiver falling edge, one status beat out per edge.
// An interval beat is registered, decoded in a single compare-and-shift step against the
// frame state, and the result is registered; one beat per cycle is sustained unless the
// output register is held by backpressure, and a result is offered on the output once its
// beat moves from the input register into the output register. Only the output register's
// backpressure stalls the input side. Depends on nir_pkg, nir_cfg, nir_core.
`include "nec_ir_frame_decoder_assert.svh"

module nec_ir_frame_decoder #(
	parameter int FRAME_BITS = nir_pkg::FRAME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,   // [15:0] interval_us
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [39:0]                         m_tdata,   // [7:0] command, [39:8] frame_word
	output logic [1:0]                          m_tuser,   // [1:0] status
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nir_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nir_pkg::TIME_W-1:0]          cfg_data
);

	nir_pkg::cfg_t                 cfg;
	nir_pkg::result_t              res;
	nir_pkg::result_t              res_s2;
	logic                          valid_s1, valid_s2, advance;
	logic [nir_pkg::TIME_W-1:0]    interval_s1;

	nir_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nir_core #(
		.FRAME_BITS (FRAME_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.interval_us (interval_s1),
		.cfg         (cfg),
		.result      (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			interval_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.frame_word, res_s2.command};
	assign m_tuser  = res_s2.status;

	`NIR_ASSERT_NOW(a_stall_only_on_backpressure, !s_tready, valid_s2 && !m_tready)
	`NIR_ASSERT_NEXT(a_step_fills_output, advance, valid_s2)

endmodule
